// ===== rtl/lrr_pkg.sv =====
// Package for the bounded LFSR random unit: widths, codes, shared types.
package lrr_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DATA_W);
  localparam int ADDR_W    = 3;
  localparam int TAP_A_BIT = 27;
  localparam int TAP_B_BIT = 30;

  localparam logic [DATA_W-1:0] SEED_RESET = DATA_W'(1);

  // register index, taken from paddr[2]
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DONE
  } state_t;

  // seed load request from the register block
  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] value;
  } seed_load_t;

  // remainder unit status
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// ===== rtl/lrr_req_if.sv =====
// Request channel: lower and upper bound per beat.
interface lrr_req_if;
  logic                      valid;
  logic                      ready;
  logic [lrr_pkg::DATA_W-1:0] lower_bound;
  logic [lrr_pkg::DATA_W-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

// ===== rtl/lrr_res_if.sv =====
// Result channel: bounded random value and range error per beat.
interface lrr_res_if;
  logic                      valid;
  logic                      ready;
  logic [lrr_pkg::DATA_W-1:0] random_value;
  logic                      range_error;

  modport source (output valid, output random_value, output range_error, input ready);
  modport sink   (input valid, input random_value, input range_error, output ready);
endinterface

// ===== rtl/lrr_apb_regs.sv =====
// APB register block holding the seed register.
module lrr_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrr_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrr_pkg::DATA_W-1:0]  pwdata,
  output logic [lrr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lrr_pkg::seed_load_t         seed_load
);
  import lrr_pkg::*;

  logic [DATA_W-1:0] seed;
  logic              wr_seed;
  logic [DATA_W-1:0] seed_wdata;

  assign pready  = 1'b1;
  assign wr_seed = psel && penable && pwrite && (paddr[2] == REG_SEED);

  // a zero seed is not stored as given, store the reset seed instead
  assign seed_wdata = (pwdata == '0) ? SEED_RESET : pwdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (wr_seed) begin
      seed <= seed_wdata;
    end
  end

  assign seed_load.load  = wr_seed;
  assign seed_load.value = seed_wdata;

  // read back; addresses with paddr[2] set read zero
  assign prdata = (paddr[2] == REG_SEED) ? seed : '0;

endmodule

// ===== rtl/lrr_rem_unit.sv =====
// Radix-2 restoring remainder unit, one quotient bit per cycle.
module lrr_rem_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lrr_pkg::DATA_W-1:0] dividend,
  input  logic [lrr_pkg::DATA_W-1:0] divisor,
  output lrr_pkg::rem_stat_t         stat,
  output logic [lrr_pkg::DATA_W-1:0] remainder
);
  import lrr_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dq;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_next;

  // shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    trial    = {rem, dq[DATA_W-1]};
    diff     = trial - {1'b0, dvs};
    rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[DATA_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

  // a finished remainder is always below the divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

  // done only follows the last iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without prior iteration");

endmodule

// ===== rtl/lfsr_random_in_range_unit.sv =====
// Top level: bounded pseudo-random values from a 32-bit XNOR shift register.
// A request is taken only while idle, so a new one waits until the last result is loaded;
// a nonzero span runs the 32 iterations of the remainder unit, a zero span skips it.
// Reset: synchronous; seed and shift register return to 1, no result pending.
// A seed write loads the shift register at once; no clearing pass is needed.
module lfsr_random_in_range_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrr_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrr_pkg::DATA_W-1:0]  pwdata,
  output logic [lrr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  lrr_req_if.sink                     req,
  lrr_res_if.source                   res
);
  import lrr_pkg::*;

  state_t            state;
  state_t            state_next;
  seed_load_t        seed_load;
  rem_stat_t         rem_stat;
  logic [DATA_W-1:0] remainder;
  logic [DATA_W-1:0] shift_state;
  logic [DATA_W-1:0] shift_next;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] lower;
  logic              zero_span;
  logic              req_beat;
  logic              rem_start;
  logic              out_load;
  logic              out_free;
  logic [DATA_W-1:0] value_next;

  lrr_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .seed_load (seed_load)
  );

  // XNOR feedback of the two taps enters at bit 0
  assign shift_next = {shift_state[DATA_W-2:0],
                       ~(shift_state[TAP_A_BIT] ^ shift_state[TAP_B_BIT])};
  assign span       = req.upper_bound - req.lower_bound;
  assign req_beat   = req.valid && req.ready;
  assign out_free   = !res.valid || res.ready;

  lrr_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (shift_next),
    .divisor   (span),
    .stat      (rem_stat),
    .remainder (remainder)
  );

  // shift register: seed load or one step per request
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_state <= SEED_RESET;
    end else if (seed_load.load) begin
      shift_state <= seed_load.value;
    end else if (req_beat) begin
      shift_state <= shift_next;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_beat) begin
      lower     <= req.lower_bound;
      zero_span <= (span == '0);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    rem_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (span == '0) begin
            state_next = S_DONE;
          end else begin
            rem_start  = 1'b1;
            state_next = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (rem_stat.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign value_next = zero_span ? lower : (remainder + lower);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.random_value <= value_next;
      res.range_error  <= zero_span;
    end
  end

  // a request beat always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> (state != S_IDLE))
    else $error("request beat did not start work");

  // while calculating, the remainder unit is iterating or just finished
  a_calc_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> (rem_stat.busy || rem_stat.done))
    else $error("calc state with idle remainder unit");

  // a loaded result shows up as valid next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> res.valid)
    else $error("loaded result not valid");

endmodule
